// ----- sv/tpc_pkg.sv -----
// shared types and constants of the thresholded pixel centroid
package tpc_pkg;

    localparam int DEPTH_W     = 8;
    localparam int ROW_LIMIT_W = 9;
    localparam int MIN_DEPTH_W = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    localparam int CENTER_X_W  = 10;
    localparam int CENTER_Y_W  = 9;
    localparam int SUM_W       = 28;
    localparam int COUNT_W     = 19;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ROW_LIMIT_W-1:0] ROW_LIMIT_RESET = 9'd280;
    localparam logic [MIN_DEPTH_W-1:0] MIN_DEPTH_RESET = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_LIMIT = 1'b0,
        REG_MIN_DEPTH = 1'b1
    } cfg_reg_t;

    // per-frame totals handed from the accumulator to the divider side
    typedef struct packed {
        logic [SUM_W-1:0]   column_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [COUNT_W-1:0] hit_count;
    } frame_sum_t;

    typedef struct packed {
        logic                  person_seen;
        logic [COUNT_W-1:0]    pixel_count;
        logic [CENTER_Y_W-1:0] center_y;
        logic [CENTER_X_W-1:0] center_x;
    } result_t;

endpackage

// ----- sv/thresholded_pixel_centroid.sv -----
// top level of the thresholded pixel centroid
// Pixels are taken one per clock while s_tready is high, in raster order; the block
// counts column and row itself. A pixel counts when its row index is at most
// row_limit and its depth is above min_depth. The last pixel of a frame (tlast)
// queues the frame totals for a pair of restoring dividers. The result word comes out
// once the totals leave the queue, the dividers work out all 28 quotient bits and the
// result is handed to the output register; only then does the divider side take a new
// frame. The totals queue holds two frames, so s_tready drops only when short frames
// arrive back to back faster than the dividers go or m_tready holds off result words.
// A frame with no counted pixel reports the frame center.
module thresholded_pixel_centroid #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // depth
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,   // center_x, center_y, pixel_count
    output logic                                m_tuser,   // person_seen
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tpc_pkg::*;

    logic [ROW_LIMIT_W-1:0] row_limit_reg;
    logic [MIN_DEPTH_W-1:0] min_depth_reg;
    logic                   cfg_write;

    logic                   push;
    frame_sum_t             push_data;
    logic                   queue_full;
    logic                   queue_empty;
    logic                   pop;
    frame_sum_t             queue_data;
    result_t                res_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_limit_reg <= ROW_LIMIT_RESET;
            min_depth_reg <= MIN_DEPTH_RESET;
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_LIMIT: row_limit_reg <= cfg_data[ROW_LIMIT_W-1:0];
                REG_MIN_DEPTH: min_depth_reg <= cfg_data[MIN_DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tpc_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_valid  (s_tvalid),
        .pix_ready  (s_tready),
        .pix_depth  (s_tdata[DEPTH_W-1:0]),
        .pix_last   (s_tlast),
        .row_limit  (row_limit_reg),
        .min_depth  (min_depth_reg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    tpc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (queue_data),
        .empty     (queue_empty)
    );

    tpc_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .queue_data  (queue_data),
        .pop         (pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (res_data)
    );

    assign m_tdata = {2'b00, res_data.pixel_count, res_data.center_y, res_data.center_x};
    assign m_tuser = res_data.person_seen;

endmodule

// ----- sv/tpc_front.sv -----
// pixel front end: raster position counters, threshold test and frame accumulators
module tpc_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  logic [tpc_pkg::DEPTH_W-1:0]         pix_depth,
    input  logic                                pix_last,
    input  logic [tpc_pkg::ROW_LIMIT_W-1:0]     row_limit,
    input  logic [tpc_pkg::MIN_DEPTH_W-1:0]     min_depth,
    output logic                                push,
    output tpc_pkg::frame_sum_t                 push_data,
    input  logic                                queue_full
);
    import tpc_pkg::*;

    localparam int COL_W = (FRAME_WIDTH > 2) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int CMP_W = (ROW_W > ROW_LIMIT_W) ? ROW_W : ROW_LIMIT_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic [COUNT_W-1:0] hit_reg, hit_next;

    logic               accept;
    logic               hit;
    logic [SUM_W:0]     col_add;
    logic [SUM_W:0]     row_add;
    frame_sum_t         acc;

    assign pix_ready = !queue_full;
    assign accept    = pix_valid && pix_ready;

    assign hit = (CMP_W'(row_reg) <= CMP_W'(row_limit)) && (pix_depth > min_depth)
                 && (hit_reg != '1);

    assign col_add = {1'b0, col_sum_reg} + (SUM_W+1)'(col_reg);
    assign row_add = {1'b0, row_sum_reg} + (SUM_W+1)'(row_reg);

    always_comb begin
        acc.column_sum = col_sum_reg;
        acc.row_sum    = row_sum_reg;
        acc.hit_count  = hit_reg;
        if (hit) begin
            acc.column_sum = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
            acc.row_sum    = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
            acc.hit_count  = hit_reg + COUNT_W'(1);
        end
    end

    assign push      = accept && pix_last;
    assign push_data = acc;

    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        hit_next     = hit_reg;
        if (accept) begin
            if (pix_last) begin
                col_next     = '0;
                row_next     = '0;
                col_sum_next = '0;
                row_sum_next = '0;
                hit_next     = '0;
            end else begin
                col_sum_next = acc.column_sum;
                row_sum_next = acc.row_sum;
                hit_next     = acc.hit_count;
                if (col_reg == COL_LAST) begin
                    col_next = '0;
                    row_next = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            hit_reg     <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
            hit_reg     <= hit_next;
        end
    end

endmodule

// ----- sv/tpc_fifo.sv -----
// short queue of frame totals between the accumulator and the divider side
module tpc_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tpc_pkg::frame_sum_t push_data,
    output logic                full,
    input  logic                pop,
    output tpc_pkg::frame_sum_t pop_data,
    output logic                empty
);
    import tpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    frame_sum_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/tpc_div.sv -----
// restoring divider, one quotient bit per cycle
module tpc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpc_pkg::SUM_W-1:0]     dividend,
    input  logic [tpc_pkg::COUNT_W-1:0]   divisor,
    output logic                          done,
    output logic [tpc_pkg::SUM_W-1:0]     quotient
);
    import tpc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [COUNT_W-1:0]  den_reg, den_next;

    logic [COUNT_W:0]    rem_shift;
    logic [COUNT_W:0]    diff;
    logic                fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

// ----- sv/tpc_back.sv -----
// back end: divides the frame totals into mean column and row and holds the result word
module tpc_back #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_empty,
    input  tpc_pkg::frame_sum_t queue_data,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output tpc_pkg::result_t    res_data
);
    import tpc_pkg::*;

    localparam logic [CENTER_X_W-1:0] HALF_W = CENTER_X_W'(FRAME_WIDTH / 2);
    localparam logic [CENTER_Y_W-1:0] HALF_H = CENTER_Y_W'(FRAME_HEIGHT / 2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] hit_reg, hit_next;
    logic               valid_reg, valid_next;
    result_t            data_reg, data_next;

    logic               div_x_done;
    logic               div_y_done;
    logic [SUM_W-1:0]   quo_x;
    logic [SUM_W-1:0]   quo_y;
    logic               out_free;
    logic               seen;

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign out_free = !valid_reg || res_ready;
    assign seen     = (hit_reg != '0);

    tpc_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pop),
        .dividend (queue_data.column_sum),
        .divisor  (queue_data.hit_count),
        .done     (div_x_done),
        .quotient (quo_x)
    );

    tpc_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pop),
        .dividend (queue_data.row_sum),
        .divisor  (queue_data.hit_count),
        .done     (div_y_done),
        .quotient (quo_y)
    );

    always_comb begin
        state_next = state_reg;
        hit_next   = hit_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && res_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    hit_next   = queue_data.hit_count;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_x_done && div_y_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    valid_next            = 1'b1;
                    data_next.center_x    = seen ? quo_x[CENTER_X_W-1:0] : HALF_W;
                    data_next.center_y    = seen ? quo_y[CENTER_Y_W-1:0] : HALF_H;
                    data_next.pixel_count = hit_reg;
                    data_next.person_seen = seen;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg  <= hit_next;
        data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res_data  = data_reg;

endmodule

// ----- tb/sv/tpc_centroid_checker.sv -----
// checker for the thresholded pixel centroid: tracks the frame sums and compares each result word
module tpc_centroid_checker #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [39:0]                     m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              frames_due
);
    import tpc_pkg::*;

    localparam logic [COUNT_W-1:0] HITS_FULL = '1;

    logic [ROW_LIMIT_W-1:0] row_limit;
    logic [MIN_DEPTH_W-1:0] min_depth;
    logic [SUM_W-1:0]       column_total;
    logic [SUM_W-1:0]       row_total;
    logic [COUNT_W-1:0]     hits;
    logic [9:0]             column_at;
    logic [8:0]             row_at;

    result_t pending_centroids[$];

    function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                      input logic [9:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-9){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic clear_frame();
        column_total = '0;
        row_total    = '0;
        hits         = '0;
        column_at    = '0;
        row_at       = '0;
    endtask

    task automatic accumulate_pixel(input logic [7:0] depth, input logic frame_end);
        result_t centroid;
        logic [SUM_W-1:0] mean_x;
        logic [SUM_W-1:0] mean_y;
        if (row_at <= row_limit && depth > min_depth && hits != HITS_FULL) begin
            column_total = add_clamped(column_total, column_at);
            row_total    = add_clamped(row_total, {1'b0, row_at});
            hits         = hits + 1'b1;
        end
        if (frame_end) begin
            if (hits != '0) begin
                mean_x = column_total / hits;
                mean_y = row_total / hits;
            end else begin
                mean_x = SUM_W'(FRAME_WIDTH / 2);
                mean_y = SUM_W'(FRAME_HEIGHT / 2);
            end
            centroid.center_x    = mean_x[CENTER_X_W-1:0];
            centroid.center_y    = mean_y[CENTER_Y_W-1:0];
            centroid.pixel_count = hits;
            centroid.person_seen = (hits != '0);
            pending_centroids.push_back(centroid);
            clear_frame();
        end else begin
            column_at = column_at + 1'b1;
            if (column_at >= FRAME_WIDTH) begin
                column_at = '0;
                row_at    = row_at + 1'b1;
                if (row_at >= FRAME_HEIGHT) begin
                    row_at = '0;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            fail_count = 0;
            row_limit  = ROW_LIMIT_RESET;
            min_depth  = MIN_DEPTH_RESET;
            clear_frame();
            pending_centroids.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.center_x    = m_tdata[9:0];
                got.center_y    = m_tdata[18:10];
                got.pixel_count = m_tdata[37:19];
                got.person_seen = m_tuser;
                if (pending_centroids.size() == 0) begin
                    note_failure($sformatf("unexpected word x=%0d y=%0d count=%0d seen=%0d",
                        got.center_x, got.center_y, got.pixel_count, got.person_seen));
                end else begin
                    want = pending_centroids.pop_front();
                    if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
                        got.pixel_count !== want.pixel_count ||
                        got.person_seen !== want.person_seen) begin
                        note_failure($sformatf({"expected x=%0d y=%0d count=%0d seen=%0d, ",
                                                "got x=%0d y=%0d count=%0d seen=%0d"},
                            want.center_x, want.center_y, want.pixel_count, want.person_seen,
                            got.center_x, got.center_y, got.pixel_count, got.person_seen));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROW_LIMIT: row_limit = cfg_data[ROW_LIMIT_W-1:0];
                    REG_MIN_DEPTH: min_depth = cfg_data[MIN_DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                accumulate_pixel(s_tdata, s_tlast);
            end
        end
        frames_due <= pending_centroids.size();
    end

endmodule

// ----- tb/sv/thresholded_pixel_centroid_tb.sv -----
// testbench top for the thresholded pixel centroid: pixel frames, register writes and verdict
module thresholded_pixel_centroid_tb;
    import tpc_pkg::*;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_ROW_LIMIT;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int                     fail_count;
    int                     frames_due;

    int                     gap_max     = 0;
    int                     burst_left  = 0;
    int                     ready_mode  = 0;
    int                     ready_hold  = 0;
    logic [MIN_DEPTH_W-1:0] min_level   = MIN_DEPTH_RESET;

    thresholded_pixel_centroid #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tpc_centroid_checker #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .frames_due(frames_due)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side back-pressure: always ready, random, or long stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 2) != 0);
                default: begin
                    m_tready   <= !m_tready;
                    ready_hold <= m_tready ? $urandom_range(0, 40) : $urandom_range(0, 10);
                end
            endcase
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (!aresetn) @(posedge aclk);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'hFF;
            2: return min_level;
            3: return (min_level == 8'hFF) ? 8'hFF : min_level + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] depth, input logic frame_end);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= depth;
        s_tlast  <= frame_end;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            push_pixel(pick_depth(), i == len - 1);
        end
    endtask

    // wait for every centroid to come back, then let the dividers settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [ROW_LIMIT_W-1:0] row_lim,
                            input logic [CFG_DATA_W-1:0] min_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ROW_LIMIT;
        cfg_data  <= row_lim;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_MIN_DEPTH;
        cfg_data  <= min_word;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_level = min_word[MIN_DEPTH_W-1:0];
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 29);
        if (r <= 5) return $urandom_range(13, 60);
        return $urandom_range(1, 12);
    endfunction

    initial begin
        int fed;
        int len;
        logic [ROW_LIMIT_W-1:0] row_lim;
        logic [CFG_DATA_W-1:0]  min_word;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: empty frame, single hit at origin, mixed depths
        push_pixel(8'd0, 1'b1);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd1, 1'b0);
        push_pixel(8'd128, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd170, 1'b0);
        push_pixel(8'd85, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b1);
        drain();
        // nothing can exceed the top threshold
        set_regs(9'd0, 9'h0FF);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd254, 1'b0);
        push_pixel(8'd1, 1'b1);
        drain();
        // unused upper data bit on the threshold write
        set_regs(9'd511, 9'h100);
        push_pixel(8'd1, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin row_lim = 9'd479; min_word = 9'd128; end
                1: begin row_lim = 9'd1;   min_word = 9'd0;   end
                2: begin row_lim = 9'd280; min_word = 9'd200; end
                3: begin row_lim = 9'd0;   min_word = 9'd0;   end
                default: begin
                    row_lim  = 9'($urandom_range(0, 511));
                    min_word = 9'($urandom_range(0, 511));
                end
            endcase
            set_regs(row_lim, min_word);
            gap_max    = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            ready_mode = $urandom_range(0, 2);
            fed = 0;
            while (fed < 60) begin
                len = pick_len();
                send_frame(len);
                fed += len;
            end
            drain();
        end

        // short frames back to back with every row taking part
        gap_max    = 0;
        ready_mode = 1;
        set_regs(9'd511, 9'd0);
        send_frame(5);
        send_frame(1);
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/tpc_pkg.sv
sv/tpc_front.sv
sv/tpc_fifo.sv
sv/tpc_div.sv
sv/tpc_back.sv
sv/thresholded_pixel_centroid.sv
tb/sv/tpc_centroid_checker.sv
tb/sv/thresholded_pixel_centroid_tb.sv
